// ===== rtl/kiss_random_generator_top_defines.svh =====
// ---------------------------------------------------------------------------
// KISS generator assertion macros
// Shared property wrappers for the generator's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef KISS_RANDOM_GENERATOR_TOP_DEFINES_SVH
`define KISS_RANDOM_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KRG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KRG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kiss_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// KISS generator package
// Word widths, generator constants, reset values and sequencer states.
// ---------------------------------------------------------------------------
package kiss_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] LCG_MUL = 32'd69069;
    localparam logic [DATA_W-1:0] LCG_ADD = 32'd12345;
    localparam logic [DATA_W-1:0] MWC_MUL = 32'd698769069;
    localparam logic [DATA_W-1:0] SEED_OFS = 32'd2;

    localparam logic [DATA_W-1:0] LCG_INIT   = 32'd123456789;
    localparam logic [DATA_W-1:0] XS_INIT    = 32'd362436000;
    localparam logic [DATA_W-1:0] MWC_INIT   = 32'd521288629;
    localparam logic [DATA_W-1:0] CARRY_INIT = 32'd7654321;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_W - 1);

    // input kind codes
    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LCG,
        ST_MWC,
        ST_CARRY,
        ST_SUM,
        ST_DIV,
        ST_OUT,
        ST_SEED_MUL,
        ST_SEED_WR
    } t_state;

endpackage

// ===== rtl/kiss_random_generator_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// KISS random generator
// Combined congruential / xorshift / multiply-with-carry generator with an
// optional modulo reduction, built around one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: tuser is the kind (draw or reseed); tdata carries limit in
//   bits [31:0] and seed in bits [63:32]. Output stream: tdata is the value.
//   A draw returns one transfer; a reseed returns nothing.
//   s_axis_tready is high only while the sequencer is idle: one item at a time.
//   Draw with zero limit: two multiplier passes, carry add, three-word sum
//   and output load, from input transfer to output valid.
//   Draw with nonzero limit: a restoring divider runs between the sum and
//   the output load, one remainder bit per cycle.
//   Reseed: multiply, write back, then ready again.
//   The result sits in an output register, so the next item is taken while
//   it waits; a stalled receiver holds the sequencer only when a new result
//   is ready to be loaded.
//   Synchronous active-low reset restores the four generator words to their
//   seed values and empties the output register.
// ---------------------------------------------------------------------------
`include "kiss_random_generator_top_defines.svh"

module kiss_random_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] limit, [63:32] seed
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] value
);

    localparam int unsigned W  = kiss_pkg::DATA_W;
    localparam int unsigned PW = kiss_pkg::PROD_W;
    localparam int unsigned CW = kiss_pkg::DIV_CNT_W;

    kiss_pkg::t_state r_state, n_state;

    logic [W-1:0]  r_lcg, n_lcg;
    logic [W-1:0]  r_xs, n_xs;
    logic [W-1:0]  r_mwc, n_mwc;
    logic [W-1:0]  r_carry, n_carry;
    logic [PW-1:0] r_prod, n_prod;
    logic [W-1:0]  r_acc, n_acc;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_limit, n_limit;
    logic [W-1:0]  r_opnd, n_opnd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic [W-1:0]  r_out_data, n_out_data;

    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic [W-1:0]  xs_1, xs_2, xs_3;
    logic [PW-1:0] mwc_t;
    logic [W:0]    rem_sh;
    logic [W:0]    rem_diff;
    logic          in_xfer;
    logic          out_free;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // shared multiplier
    assign mul_p = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

    assign xs_1 = r_xs ^ (r_xs << 13);
    assign xs_2 = xs_1 ^ (xs_1 >> 17);
    assign xs_3 = xs_2 ^ (xs_2 << 5);

    assign mwc_t    = r_prod + {{W{1'b0}}, r_carry};
    assign rem_sh   = {r_rem, r_acc[W-1]};
    assign rem_diff = rem_sh - {1'b0, r_limit};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kiss_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (s_axis_tuser == kiss_pkg::KIND_RESEED) ?
                              kiss_pkg::ST_SEED_MUL : kiss_pkg::ST_LCG;
                end
            end
            kiss_pkg::ST_LCG:      n_state = kiss_pkg::ST_MWC;
            kiss_pkg::ST_MWC:      n_state = kiss_pkg::ST_CARRY;
            kiss_pkg::ST_CARRY:    n_state = kiss_pkg::ST_SUM;
            kiss_pkg::ST_SUM: begin
                n_state = (r_limit == '0) ? kiss_pkg::ST_OUT : kiss_pkg::ST_DIV;
            end
            kiss_pkg::ST_DIV: begin
                if (r_cnt == kiss_pkg::DIV_LAST) begin
                    n_state = kiss_pkg::ST_OUT;
                end
            end
            kiss_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = kiss_pkg::ST_IDLE;
                end
            end
            kiss_pkg::ST_SEED_MUL: n_state = kiss_pkg::ST_SEED_WR;
            kiss_pkg::ST_SEED_WR:  n_state = kiss_pkg::ST_IDLE;
            default:               n_state = kiss_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_axis_tready = 1'b0;
        mul_a         = r_mwc;
        mul_b         = r_opnd;
        n_lcg         = r_lcg;
        n_xs          = r_xs;
        n_mwc         = r_mwc;
        n_carry       = r_carry;
        n_prod        = r_prod;
        n_acc         = r_acc;
        n_rem         = r_rem;
        n_limit       = r_limit;
        n_opnd        = r_opnd;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_data    = r_out_data;
        unique case (r_state)
            kiss_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                n_limit       = s_axis_tdata[W-1:0];
                n_opnd        = s_axis_tdata[2*W-1:W] + kiss_pkg::SEED_OFS;
            end
            kiss_pkg::ST_LCG: begin
                mul_a  = r_lcg;
                mul_b  = kiss_pkg::LCG_MUL;
                n_prod = mul_p;
                n_xs   = xs_3;
            end
            kiss_pkg::ST_MWC: begin
                mul_a  = r_mwc;
                mul_b  = kiss_pkg::MWC_MUL;
                n_prod = mul_p;
                n_lcg  = r_prod[W-1:0] + kiss_pkg::LCG_ADD;
            end
            kiss_pkg::ST_CARRY: begin
                n_mwc   = mwc_t[W-1:0];
                n_carry = mwc_t[PW-1:W];
            end
            kiss_pkg::ST_SUM: begin
                n_acc = r_lcg + r_xs + r_mwc;
                n_rem = '0;
                n_cnt = '0;
            end
            kiss_pkg::ST_DIV: begin
                // one restoring step: shift in the next dividend bit
                n_rem = (rem_sh >= {1'b0, r_limit}) ? rem_diff[W-1:0] : rem_sh[W-1:0];
                n_acc = {r_acc[W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
            end
            kiss_pkg::ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (r_limit == '0) ? r_acc : r_rem;
                end
            end
            kiss_pkg::ST_SEED_MUL: begin
                mul_a  = r_mwc;
                mul_b  = r_opnd;
                n_prod = mul_p;
            end
            kiss_pkg::ST_SEED_WR: begin
                n_mwc = r_prod[W-1:0];
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kiss_pkg::ST_IDLE;
            r_lcg       <= kiss_pkg::LCG_INIT;
            r_xs        <= kiss_pkg::XS_INIT;
            r_mwc       <= kiss_pkg::MWC_INIT;
            r_carry     <= kiss_pkg::CARRY_INIT;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_lcg       <= n_lcg;
            r_xs        <= n_xs;
            r_mwc       <= n_mwc;
            r_carry     <= n_carry;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_limit    <= n_limit;
        r_opnd     <= n_opnd;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `KRG_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !s_axis_tready,
        "sequencer ready again right after an input transfer")
    `KRG_ASSERT_NOW(a_rem_below_limit, (r_state == kiss_pkg::ST_OUT) && (r_limit != '0),
        r_rem < r_limit, "remainder not below limit")
    `KRG_ASSERT_NEXT(a_div_ends, (r_state == kiss_pkg::ST_DIV) && (r_cnt == kiss_pkg::DIV_LAST),
        r_state == kiss_pkg::ST_OUT, "divider did not finish after last step")
    `KRG_ASSERT_NEXT(a_reseed_keeps, r_state == kiss_pkg::ST_SEED_MUL,
        $stable(r_lcg) && $stable(r_xs) && $stable(r_carry),
        "reseed disturbed lcg, xorshift or carry word")

endmodule
